// File: design/c8ex_pkg.sv
// Package for the CHIP-8 execute unit: sizes, opcode and word constants,
// and the structs passed between the execute logic, the V register file and the top level.
// No dependencies.
`default_nettype none

package c8ex_pkg;

	// Return stack geometry
	localparam int STACK_DEPTH = 16;
	localparam int STK_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int LVL_W = $clog2(STACK_DEPTH + 1);

	// Reset program counter
	localparam logic [11:0] PC_RESET = 12'h200;

	// Stream widths
	localparam int IN_TDATA_W = 24;
	localparam int RES_W = 44;
	localparam int OUT_TDATA_W = 48;

	// Major opcodes (top nibble)
	localparam logic [3:0] OP_SYS  = 4'h0;
	localparam logic [3:0] OP_JP   = 4'h1;
	localparam logic [3:0] OP_CALL = 4'h2;
	localparam logic [3:0] OP_SEB  = 4'h3;
	localparam logic [3:0] OP_SNEB = 4'h4;
	localparam logic [3:0] OP_SER  = 4'h5;
	localparam logic [3:0] OP_LDB  = 4'h6;
	localparam logic [3:0] OP_ADDB = 4'h7;
	localparam logic [3:0] OP_ALU  = 4'h8;
	localparam logic [3:0] OP_SNER = 4'h9;
	localparam logic [3:0] OP_LDI  = 4'hA;
	localparam logic [3:0] OP_JPV0 = 4'hB;
	localparam logic [3:0] OP_KEY  = 4'hE;
	localparam logic [3:0] OP_MISC = 4'hF;

	// 8XYN function codes
	localparam logic [3:0] FN_MOV  = 4'h0;
	localparam logic [3:0] FN_OR   = 4'h1;
	localparam logic [3:0] FN_AND  = 4'h2;
	localparam logic [3:0] FN_XOR  = 4'h3;
	localparam logic [3:0] FN_ADD  = 4'h4;
	localparam logic [3:0] FN_SUB  = 4'h5;
	localparam logic [3:0] FN_SHR  = 4'h6;
	localparam logic [3:0] FN_SUBN = 4'h7;
	localparam logic [3:0] FN_SHL  = 4'hE;

	// Full words and low-byte sub-codes
	localparam logic [15:0] W_CLS   = 16'h00E0;
	localparam logic [15:0] W_RET   = 16'h00EE;
	localparam logic [7:0]  NN_SKP  = 8'h9E;
	localparam logic [7:0]  NN_SKNP = 8'hA1;
	localparam logic [7:0]  NN_ADDI = 8'h1E;

	// Flag register number
	localparam logic [3:0] REG_VF = 4'hF;

	// Result item, next_pc in the lowest bits
	typedef struct packed {
		logic        unsupported;
		logic        stack_fault;
		logic        clear_request;
		logic [15:0] index_value;
		logic [7:0]  write_value;
		logic [3:0]  write_reg;
		logic        write_valid;
		logic [11:0] next_pc;
	} res_t;

	// V register file write request
	typedef struct packed {
		logic       x_we;
		logic [3:0] x_wa;
		logic [7:0] x_wd;
		logic       f_we;
		logic [7:0] f_wd;
	} vreg_wr_t;

	// State update from one executed instruction
	typedef struct packed {
		logic [11:0] pc;
		logic [15:0] idx;
		logic        push;
		logic        pop;
		vreg_wr_t    vwr;
	} upd_t;

endpackage

`default_nettype wire

// File: design/c8ex_vregs.sv
// V register file: V0..VE in a small memory with reset-valid bits, VF in a flop.
// Two registered read ports with bypass of the write in the same cycle. Uses c8ex_pkg.
`default_nettype none

module c8ex_vregs (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rd_en,
	input  wire logic [3:0]        rd_xa,
	input  wire logic [3:0]        rd_ya,
	input  wire c8ex_pkg::vreg_wr_t wr,
	output logic [7:0]             rd_xd,
	output logic [7:0]             rd_yd
);
	import c8ex_pkg::*;

	logic [7:0]  mem [16];
	logic [15:0] vld_q;
	logic [7:0]  vf_q;
	logic [7:0]  x_now;
	logic [7:0]  y_now;
	logic [7:0]  rd_xd_q;
	logic [7:0]  rd_yd_q;

	// Look up one address, bypassing a write that lands this cycle
	function automatic logic [7:0] rd_byp(input logic [3:0] a, input vreg_wr_t w,
		input logic [7:0] mdat, input logic mvld, input logic [7:0] vf);
		logic [7:0] v;
		if (a == REG_VF) begin
			v = w.f_we ? w.f_wd : vf;
		end else if (w.x_we && (w.x_wa == a)) begin
			v = w.x_wd;
		end else begin
			v = mvld ? mdat : 8'h00;
		end
		return v;
	endfunction

	always_comb begin
		x_now = rd_byp(rd_xa, wr, mem[rd_xa], vld_q[rd_xa], vf_q);
		y_now = rd_byp(rd_ya, wr, mem[rd_ya], vld_q[rd_ya], vf_q);
	end

	// Write the memory entry
	always_ff @(posedge clk) begin
		if (wr.x_we) begin
			mem[wr.x_wa] <= wr.x_wd;
		end
	end

	// Track written entries and the flag register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			vf_q  <= '0;
		end else begin
			if (wr.x_we) begin
				vld_q[wr.x_wa] <= 1'b1;
			end
			if (wr.f_we) begin
				vf_q <= wr.f_wd;
			end
		end
	end

	// Register the read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_xd_q <= x_now;
			rd_yd_q <= y_now;
		end
	end

	assign rd_xd = rd_xd_q;
	assign rd_yd = rd_yd_q;

endmodule

`default_nettype wire

// File: design/c8ex_exec.sv
// Execute logic: decodes one instruction and computes the result item and state update.
// Purely combinational. Uses c8ex_pkg.
`default_nettype none

module c8ex_exec (
	input  wire logic [15:0]               instr,
	input  wire logic                      key_pressed,
	input  wire logic [3:0]                key_code,
	input  wire logic [7:0]                vx,
	input  wire logic [7:0]                vy,
	input  wire logic [11:0]               pc,
	input  wire logic [15:0]               idx,
	input  wire logic [c8ex_pkg::LVL_W-1:0] level,
	input  wire logic [11:0]               stack_top,
	output c8ex_pkg::res_t                 res,
	output c8ex_pkg::upd_t                 upd
);
	import c8ex_pkg::*;

	logic [3:0]  op;
	logic [3:0]  x;
	logic [3:0]  n;
	logic [7:0]  nn;
	logic [11:0] nnn;
	logic [11:0] pc_inc;
	logic [11:0] pc_skip;
	logic [8:0]  sum9;
	logic        wr_en;
	logic        has_f;
	logic [7:0]  r;
	logic [7:0]  f;

	assign op      = instr[15:12];
	assign x       = instr[11:8];
	assign n       = instr[3:0];
	assign nn      = instr[7:0];
	assign nnn     = instr[11:0];
	assign pc_inc  = pc + 12'd2;
	assign pc_skip = pc + 12'd4;
	assign sum9    = {1'b0, vx} + {1'b0, vy};

	// Decode and execute
	always_comb begin
		res   = '0;
		upd   = '0;
		upd.pc  = pc_inc;
		upd.idx = idx;
		wr_en = 1'b0;
		has_f = 1'b0;
		r     = 8'h00;
		f     = 8'h00;

		unique case (op)
			OP_SYS: begin
				if (instr == W_CLS) begin
					res.clear_request = 1'b1;
				end else if (instr == W_RET) begin
					if (level == '0) begin
						res.stack_fault = 1'b1;
					end else begin
						upd.pop = 1'b1;
						upd.pc  = stack_top;
					end
				end else begin
					res.unsupported = 1'b1;
				end
			end
			OP_JP: upd.pc = nnn;
			OP_CALL: begin
				if (level >= LVL_W'(STACK_DEPTH)) begin
					res.stack_fault = 1'b1;
				end else begin
					upd.push = 1'b1;
					upd.pc   = nnn;
				end
			end
			OP_SEB: begin
				if (vx == nn) upd.pc = pc_skip;
			end
			OP_SNEB: begin
				if (vx != nn) upd.pc = pc_skip;
			end
			OP_SER, OP_SNER: begin
				if (n != 4'h0) begin
					res.unsupported = 1'b1;
				end else if ((op == OP_SER) == (vx == vy)) begin
					upd.pc = pc_skip;
				end
			end
			OP_LDB: begin
				wr_en = 1'b1;
				r     = nn;
			end
			OP_ADDB: begin
				wr_en = 1'b1;
				r     = vx + nn;
			end
			OP_ALU: begin
				wr_en = 1'b1;
				unique case (n)
					FN_MOV: r = vy;
					FN_OR:  r = vx | vy;
					FN_AND: r = vx & vy;
					FN_XOR: r = vx ^ vy;
					FN_ADD: begin
						r     = sum9[7:0];
						f     = {7'd0, sum9[8]};
						has_f = 1'b1;
					end
					FN_SUB: begin
						r     = vx - vy;
						f     = {7'd0, (vx >= vy)};
						has_f = 1'b1;
					end
					FN_SHR: begin
						r     = {1'b0, vx[7:1]};
						f     = {7'd0, vx[0]};
						has_f = 1'b1;
					end
					FN_SUBN: begin
						r     = vy - vx;
						f     = {7'd0, (vy >= vx)};
						has_f = 1'b1;
					end
					FN_SHL: begin
						r     = {vx[6:0], 1'b0};
						f     = {7'd0, vx[7]};
						has_f = 1'b1;
					end
					default: begin
						wr_en           = 1'b0;
						res.unsupported = 1'b1;
					end
				endcase
			end
			OP_LDI: upd.idx = {4'd0, nnn};
			OP_JPV0: upd.pc = {4'd0, vy} + nnn;
			OP_KEY: begin
				if (nn == NN_SKP) begin
					if (key_pressed && (key_code == vx[3:0]) && (vx[7:4] == 4'd0)) begin
						upd.pc = pc_skip;
					end
				end else if (nn == NN_SKNP) begin
					if (!key_pressed || (key_code != vx[3:0]) || (vx[7:4] != 4'd0)) begin
						upd.pc = pc_skip;
					end
				end else begin
					res.unsupported = 1'b1;
				end
			end
			OP_MISC: begin
				if (nn == NN_ADDI) begin
					upd.idx = idx + {8'd0, vx};
				end else begin
					res.unsupported = 1'b1;
				end
			end
			default: res.unsupported = 1'b1;
		endcase

		// Route the register write; the flag wins when the destination is VF
		if (wr_en) begin
			res.write_valid = 1'b1;
			res.write_reg   = x;
			if (x == REG_VF) begin
				upd.vwr.f_we    = 1'b1;
				upd.vwr.f_wd    = has_f ? f : r;
				res.write_value = has_f ? f : r;
			end else begin
				upd.vwr.x_we    = 1'b1;
				upd.vwr.x_wa    = x;
				upd.vwr.x_wd    = r;
				upd.vwr.f_we    = has_f;
				upd.vwr.f_wd    = f;
				res.write_value = r;
			end
		end

		res.next_pc     = upd.pc;
		res.index_value = upd.idx;
	end

endmodule

`default_nettype wire

// File: design/chip8_alu_branch_core.sv
// Top level of the CHIP-8 execute unit: stream ports, stage-1 register, program counter,
// index register, return stack and result register. Uses c8ex_pkg, c8ex_vregs, c8ex_exec.
//
//  channel | dir | tdata fields, lowest bit first                          | tuser
//  s_*     | in  | instr_word[15:0] key_pressed[16] key_code[20:17]         | -
//  m_*     | out | next_pc[11:0] write_valid[12] write_reg[16:13]           | -
//          |     | write_value[24:17] index_value[40:25] clear_request[41]  |
//          |     | stack_fault[42] unsupported[43]                          |
//
// One instruction per cycle sustained while the result output is not stalled. The first step
// reads the V register file into the stage-1 register; the second step executes and commits
// state while loading the result register.
// Reset: pc = 0x200, V registers, index and stack level zero.
// A stalled result holds the stage-1 item; a new item is still taken when stage 1 empties.
`default_nettype none

module chip8_alu_branch_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [c8ex_pkg::IN_TDATA_W-1:0]  s_tdata,   // instr_word, key_pressed, key_code
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// m_tdata: next_pc, write_valid, write_reg, write_value, index_value,
	// clear_request, stack_fault, unsupported
	output logic [c8ex_pkg::OUT_TDATA_W-1:0]      m_tdata
);
	import c8ex_pkg::*;

	logic              in_xfer;
	logic              adv;
	logic              valid_s1;
	logic [15:0]       instr_s1;
	logic              keyp_s1;
	logic [3:0]        keyc_s1;
	logic [7:0]        vx_s1;
	logic [7:0]        vy_s1;
	logic [3:0]        rd_ya;
	logic [11:0]       pc_q;
	logic [15:0]       idx_q;
	logic [LVL_W-1:0]  lvl_q;
	logic [LVL_W-1:0]  lvl_m1;
	logic [11:0]       stk_q [STACK_DEPTH];
	logic [11:0]       stack_top;
	res_t              res;
	upd_t              upd;
	vreg_wr_t          vwr;
	res_t              out_q;
	logic              out_vld_q;

	// Handshake: stage 1 moves on when the result register is free or being drained
	assign adv      = valid_s1 && (!out_vld_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign in_xfer  = s_tvalid && s_tready;

	// Jump via V0 reads V0 on the second port
	assign rd_ya = (s_tdata[15:12] == OP_JPV0) ? 4'h0 : s_tdata[7:4];

	// Commit register writes only when the instruction retires
	always_comb begin
		vwr      = upd.vwr;
		vwr.x_we = upd.vwr.x_we && adv;
		vwr.f_we = upd.vwr.f_we && adv;
	end

	c8ex_vregs u_vregs (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (in_xfer),
		.rd_xa  (s_tdata[11:8]),
		.rd_ya  (rd_ya),
		.wr     (vwr),
		.rd_xd  (vx_s1),
		.rd_yd  (vy_s1)
	);

	// Stage-1 item register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			instr_s1 <= s_tdata[15:0];
			keyp_s1  <= s_tdata[16];
			keyc_s1  <= s_tdata[20:17];
		end
	end

	// Top of the return stack
	assign lvl_m1    = lvl_q - 1'b1;
	assign stack_top = stk_q[lvl_m1[STK_AW-1:0]];

	c8ex_exec u_exec (
		.instr       (instr_s1),
		.key_pressed (keyp_s1),
		.key_code    (keyc_s1),
		.vx          (vx_s1),
		.vy          (vy_s1),
		.pc          (pc_q),
		.idx         (idx_q),
		.level       (lvl_q),
		.stack_top   (stack_top),
		.res         (res),
		.upd         (upd)
	);

	// Architectural state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= PC_RESET;
			idx_q     <= '0;
			lvl_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (adv) begin
				pc_q  <= upd.pc;
				idx_q <= upd.idx;
				if (upd.push) begin
					lvl_q <= lvl_q + 1'b1;
				end else if (upd.pop) begin
					lvl_q <= lvl_m1;
				end
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Push the return address
	always_ff @(posedge clk) begin
		if (adv && upd.push) begin
			stk_q[lvl_q[STK_AW-1:0]] <= pc_q + 12'd2;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, out_q};

endmodule

`default_nettype wire
